// ===== hdl/rpn_pkg.sv =====
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PRINT = 8'h70;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] KIND_TOP       = 2'd0;
   localparam logic [1:0] KIND_EMPTY     = 2'd1;
   localparam logic [1:0] KIND_UNDERFLOW = 2'd2;
   localparam logic [1:0] KIND_DIVZERO   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DISPATCH,
      ST_EXECUTE,
      ST_DIV_WAIT,
      ST_WRITE_BACK,
      ST_REPORT
   } ctrl_state_type;

   typedef struct packed {
      logic       load_char;
      logic       acc_step;
      logic       push_acc;
      logic       read_ops;
      logic       alu_capture;
      logic       div_start;
      logic       div_capture;
      logic       write_back;
      logic       set_report;
      logic [1:0] report_kind;
      logic       load_report;
   } dp_cmd_type;

   typedef struct packed {
      logic is_digit;
      logic in_number;
      logic is_op;
      logic is_print;
      logic is_div;
      logic depth_lt2;
      logic depth_zero;
      logic op2_zero;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hdl/rpn_req_if.sv =====
interface rpn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// ===== hdl/rpn_rsp_if.sv =====
interface rpn_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  report_kind;
   logic signed [31:0] report_value;

   modport source (output valid, output report_kind, output report_value, input ready);
   modport sink (input valid, input report_kind, input report_value, output ready);
endinterface

// ===== hdl/rpn_divider.sv =====
module rpn_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpn_pkg::DATA_W-1:0] dividend,
   input  logic [rpn_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [rpn_pkg::DATA_W-1:0] quotient
);
   import rpn_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 neg_ff;
   logic [DATA_W-1:0]    mag_b_ff;
   logic [DATA_W-1:0]    rem_ff;
   logic [DATA_W-1:0]    quo_ff;
   logic [DATA_W-1:0]    rem_shift;
   logic                 fits;

   // The remainder stays below the divisor magnitude (at most 2^31), so the
   // shifted remainder never loses its top bit.
   assign rem_shift = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
   assign fits      = (rem_shift >= mag_b_ff);
   assign done      = busy_ff && (count_ff == '0);
   assign quotient  = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         count_ff <= count_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         mag_b_ff <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
         quo_ff   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         rem_ff   <= '0;
      end else if (busy_ff && (count_ff != '0)) begin
         rem_ff <= fits ? (rem_shift - mag_b_ff) : rem_shift;
         quo_ff <= {quo_ff[DATA_W-2:0], fits};
      end
   end

endmodule

// ===== hdl/rpn_datapath.sv =====
module rpn_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    char_in,
   input  rpn_pkg::dp_cmd_type           cmd,
   output rpn_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic signed [rpn_pkg::DATA_W-1:0] rsp_value
);
   import rpn_pkg::*;

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];

   logic [7:0]          char_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [DEPTH_W-1:0]  depth_in;
   logic [DATA_W-1:0]   acc_ff;
   logic [DATA_W-1:0]   acc_in;
   logic                in_num_ff;
   logic                in_num_in;
   logic [DATA_W-1:0]   rd_a_ff;
   logic [DATA_W-1:0]   rd_b_ff;
   logic [DATA_W-1:0]   res_ff;
   logic [1:0]          pend_kind_ff;
   logic [DATA_W-1:0]   pend_value_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_kind_ff;
   logic [DATA_W-1:0]   rsp_value_ff;

   logic [DEPTH_W-1:0]  depth_m1;
   logic [DEPTH_W-1:0]  depth_m2;
   logic                full;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   digit_val;
   logic [2*DATA_W-1:0] product;
   logic [DATA_W-1:0]   div_quotient;
   logic                div_done;

   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign full      = (depth_ff >= DEPTH_W'(STACK_DEPTH));
   assign digit_val = DATA_W'(char_ff - CHAR_ZERO);
   assign product   = rd_b_ff * rd_a_ff;

   assign status.is_digit   = char_ff inside {[CHAR_ZERO:CHAR_NINE]};
   assign status.in_number  = in_num_ff;
   assign status.is_op      = char_ff inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};
   assign status.is_print   = (char_ff == CHAR_PRINT);
   assign status.is_div     = (char_ff == CHAR_SLASH);
   assign status.depth_lt2  = (depth_ff < DEPTH_W'(2));
   assign status.depth_zero = (depth_ff == '0);
   assign status.op2_zero   = (rd_a_ff == '0);
   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_b_ff),
      .divisor  (rd_a_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Digits fold in as acc*10 + digit; the pending number is pushed (or
   // dropped when the stack is full) on the first non-digit.
   always_comb begin
      acc_in    = acc_ff;
      in_num_in = in_num_ff;
      depth_in  = depth_ff;
      if (cmd.acc_step) begin
         acc_in    = (acc_ff << 3) + (acc_ff << 1) + digit_val;
         in_num_in = 1'b1;
      end else if (cmd.push_acc) begin
         acc_in    = '0;
         in_num_in = 1'b0;
         if (!full) begin
            depth_in = depth_ff + DEPTH_W'(1);
         end
      end else if (cmd.write_back) begin
         depth_in = depth_m1;
      end
   end

   always_comb begin
      wr_en   = (cmd.push_acc && !full) || cmd.write_back;
      wr_addr = cmd.push_acc ? depth_ff[ADDR_W-1:0] : depth_m2[ADDR_W-1:0];
      wr_data = cmd.push_acc ? acc_ff : res_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (cmd.read_ops) begin
         rd_a_ff <= stack_mem[depth_m1[ADDR_W-1:0]];
         rd_b_ff <= stack_mem[depth_m2[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         acc_ff    <= acc_in;
         in_num_ff <= in_num_in;
         if (cmd.load_report) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= char_in;
      end
      if (cmd.alu_capture) begin
         case (char_ff)
            CHAR_PLUS:  res_ff <= rd_b_ff + rd_a_ff;
            CHAR_MINUS: res_ff <= rd_b_ff - rd_a_ff;
            default:    res_ff <= product[DATA_W-1:0];
         endcase
      end else if (cmd.div_capture) begin
         res_ff <= div_quotient;
      end
      if (cmd.set_report) begin
         pend_kind_ff  <= cmd.report_kind;
         pend_value_ff <= (cmd.report_kind == KIND_TOP) ? rd_a_ff : '0;
      end
      if (cmd.load_report) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_value_ff <= pend_value_ff;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_writeback_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.write_back |-> depth_ff >= DEPTH_W'(2))
      else $error("result written back with fewer than two operands");

   a_report_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.load_report |=> rsp_valid_ff)
      else $error("report loaded but result not valid");

   a_acc_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !in_num_ff |-> acc_ff == '0)
      else $error("accumulator nonzero with no digits pending");

endmodule

// ===== hdl/rpn_controller.sv =====
module rpn_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpn_pkg::dp_status_type status,
   output rpn_pkg::dp_cmd_type    cmd
);
   import rpn_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.is_digit ? ST_IDLE : ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.is_op) begin
               state_in = status.depth_lt2 ? ST_REPORT : ST_EXECUTE;
            end else if (status.is_print) begin
               state_in = status.depth_zero ? ST_REPORT : ST_EXECUTE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EXECUTE: begin
            if (status.is_print) begin
               state_in = ST_REPORT;
            end else if (status.is_div) begin
               state_in = status.op2_zero ? ST_REPORT : ST_DIV_WAIT;
            end else begin
               state_in = ST_WRITE_BACK;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_WRITE_BACK;
            end
         end
         ST_WRITE_BACK: begin
            state_in = ST_IDLE;
         end
         ST_REPORT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_char = req_valid;
         end
         ST_DECODE: begin
            cmd.acc_step = status.is_digit;
            cmd.push_acc = !status.is_digit && status.in_number;
         end
         ST_DISPATCH: begin
            if (status.is_op) begin
               if (status.depth_lt2) begin
                  cmd.set_report  = 1'b1;
                  cmd.report_kind = KIND_UNDERFLOW;
               end else begin
                  cmd.read_ops = 1'b1;
               end
            end else if (status.is_print) begin
               if (status.depth_zero) begin
                  cmd.set_report  = 1'b1;
                  cmd.report_kind = KIND_EMPTY;
               end else begin
                  cmd.read_ops = 1'b1;
               end
            end
         end
         ST_EXECUTE: begin
            if (status.is_print) begin
               cmd.set_report  = 1'b1;
               cmd.report_kind = KIND_TOP;
            end else if (status.is_div) begin
               if (status.op2_zero) begin
                  cmd.set_report  = 1'b1;
                  cmd.report_kind = KIND_DIVZERO;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end else begin
               cmd.alu_capture = 1'b1;
            end
         end
         ST_DIV_WAIT: begin
            cmd.div_capture = status.div_done;
         end
         ST_WRITE_BACK: begin
            cmd.write_back = 1'b1;
         end
         ST_REPORT: begin
            cmd.load_report = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/rpn_stack_calculator_unit.sv =====
// Reverse-Polish integer calculator that takes one character per item and
// gives at most one report item per character. Items are handled one at a
// time: a digit passes through decode; an ignored character also through
// dispatch; an underflow or empty-stack report goes from dispatch to report;
// '+', '-', '*', 'p' with a value and a divide by zero pass execute; '/'
// also waits on the divider, which retires one quotient bit per cycle over
// 32 steps. A report waits in an output register; the block takes the next
// item while it is pending, and a further report holds the block until
// the first one is taken. The operand stack is a 16-entry memory with
// registered reads; a number pushed onto a full stack is dropped unreported.
module rpn_stack_calculator_unit (
   input logic  clock,
   input logic  reset,
   rpn_req_if.sink   req_chan,
   rpn_rsp_if.source rsp_chan
);
   import rpn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          rsp_valid;
   logic [1:0]    rsp_kind;
   logic signed [DATA_W-1:0] rsp_value;

   rpn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .char_in   (req_chan.char_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_kind  (rsp_kind),
      .rsp_value (rsp_value)
   );

   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.report_kind  = rsp_kind;
   assign rsp_chan.report_value = rsp_value;

endmodule

// ===== tb/sv/tb_rpn_stack_calculator_unit.sv =====
module tb_rpn_stack_calculator_unit;
   import rpn_pkg::*;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_CHARS = 560;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } report_type;

   typedef struct {
      logic [7:0] ch;
      bit         fixed;
      report_type rep;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpn_req_if req_chan ();
   rpn_rsp_if rsp_chan ();

   rpn_stack_calculator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   // Calculator state as the predictor sees it.
   logic [31:0] calc_stack [STACK_DEPTH];
   int          calc_depth = 0;
   logic [31:0] calc_acc = '0;
   bit          calc_in_number = 1'b0;

   report_type   pending_reports [$];
   stim_row_type directed_rows [$];
   int        errors = 0;
   int        chars_sent = 0;
   int        stall_cycles = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   function automatic void push_operand(input logic [31:0] v);
      if (calc_depth < STACK_DEPTH) begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endfunction

   function automatic logic [31:0] quotient_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   function automatic void calc_apply_char(input logic [7:0] ch, output bit emits,
                                           output report_type rep);
      logic [31:0] op1, op2, res;
      emits = 1'b0;
      rep = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         calc_acc = calc_acc * 32'd10 + 32'(ch - CHAR_ZERO);
         calc_in_number = 1'b1;
         return;
      end
      // The first non-digit closes a pending number before it is handled itself.
      if (calc_in_number) begin
         push_operand(calc_acc);
         calc_acc = '0;
         calc_in_number = 1'b0;
      end
      case (ch)
         CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
            if (calc_depth < 2) begin
               emits = 1'b1;
               rep.kind = KIND_UNDERFLOW;
               return;
            end
            op2 = calc_stack[calc_depth - 1];
            op1 = calc_stack[calc_depth - 2];
            if (ch == CHAR_SLASH && op2 == '0) begin
               emits = 1'b1;
               rep.kind = KIND_DIVZERO;
               return;
            end
            case (ch)
               CHAR_PLUS:  res = op1 + op2;
               CHAR_MINUS: res = op1 - op2;
               CHAR_STAR:  res = op1 * op2;
               default:    res = quotient_trunc(op1, op2);
            endcase
            calc_depth -= 2;
            push_operand(res);
         end
         CHAR_PRINT: begin
            emits = 1'b1;
            if (calc_depth == 0) begin
               rep.kind = KIND_EMPTY;
            end else begin
               rep.kind = KIND_TOP;
               rep.value = calc_stack[calc_depth - 1];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input logic [7:0] ch);
      stim_row_type row;
      row.ch = ch;
      row.fixed = 1'b0;
      row.rep = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic [7:0] ch, input logic [1:0] kind,
                                       input logic [31:0] value);
      stim_row_type row;
      row.ch = ch;
      row.fixed = 1'b1;
      row.rep.kind = kind;
      row.rep.value = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_digits(input string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i]);
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_char(input logic [7:0] ch, input bit fixed = 1'b0,
                            input report_type fixed_rep = '0);
      bit         emits;
      report_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.char_in <= ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
      calc_apply_char(ch, emits, rep);
      if (fixed) pending_reports.push_back(fixed_rep);
      else if (emits) pending_reports.push_back(rep);
      @(negedge clock);
   endtask

   task automatic drain_reports();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_number();
      string      s;
      int         len;
      logic [7:0] sep;
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(5))
            0:       s = "2147483647";
            1:       s = "2147483648";
            2:       s = "4294967295";
            3:       s = "9999999999";
            4:       s = "0";
            default: s = "1";
         endcase
         for (int i = 0; i < s.len(); i++) send_char(s[i]);
      end else begin
         len = ($urandom_range(3) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
         for (int i = 0; i < len; i++) send_char(CHAR_ZERO + 8'($urandom_range(9)));
      end
      // Without a separator the next token closes the number, or extends it.
      case ($urandom_range(9))
         0, 1, 2, 3, 4: send_char(CHAR_SPACE);
         5, 6, 7: begin
            do sep = 8'($urandom_range(255));
            while (sep >= CHAR_ZERO && sep <= CHAR_NINE);
            send_char(sep);
         end
         default: ;
      endcase
   endtask

   task automatic run_random(input int n_chars);
      int first;
      int push_pct;
      int r;
      first = chars_sent;
      push_pct = 50;
      while (chars_sent - first < n_chars) begin
         // Shift between growing and shrinking the stack so both full and
         // empty stacks come up.
         if ($urandom_range(39) == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 25;
               1:       push_pct = 50;
               default: push_pct = 80;
            endcase
         end
         r = $urandom_range(99);
         if (r < push_pct) begin
            send_number();
         end else if (r < push_pct + 8) begin
            send_char(CHAR_PRINT);
         end else if (r < push_pct + 12) begin
            send_char(8'($urandom_range(255)));
         end else begin
            case ($urandom_range(3))
               0:       send_char(CHAR_PLUS);
               1:       send_char(CHAR_MINUS);
               2:       send_char(CHAR_STAR);
               default: send_char(CHAR_SLASH);
            endcase
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_reports
      report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, kind %0d value %0d", $time,
                     rsp_chan.report_kind, rsp_chan.report_value);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_chan.report_kind !== want.kind) begin
               $display("%0t: report_kind expected %0d actual %0d", $time,
                        want.kind, rsp_chan.report_kind);
               errors++;
            end
            if (rsp_chan.report_value !== want.value) begin
               $display("%0t: report_value expected %0d actual %0d", $time,
                        want.value, rsp_chan.report_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.char_in = '0;
      rsp_chan.ready = 1'b0;

      add_checked(CHAR_PRINT, KIND_EMPTY, 32'd0);
      add_checked(CHAR_STAR, KIND_UNDERFLOW, 32'd0);
      add_digits("0");
      add_checked(CHAR_PRINT, KIND_TOP, 32'd0);
      add_checked(CHAR_SLASH, KIND_UNDERFLOW, 32'd0);
      // Wraps to the most negative value; an ignored byte pushes it.
      add_digits("2147483648");
      add_row(8'hFF);
      add_digits("1");
      add_row(8'h00);
      add_digits("2");
      add_row(CHAR_MINUS);
      // Most negative value divided by -1 stays the most negative value.
      add_row(CHAR_SLASH);
      add_checked(CHAR_PRINT, KIND_TOP, 32'h8000_0000);
      add_digits("0");
      add_checked(CHAR_SLASH, KIND_DIVZERO, 32'd0);
      add_row(CHAR_PLUS);
      add_digits("1");
      add_row(CHAR_MINUS);
      add_checked(CHAR_PRINT, KIND_TOP, 32'h7FFF_FFFF);

      send_idle_pct = 19;
      recv_idle_pct = 73;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_char(directed_rows[i].ch, directed_rows[i].fixed,
                                           directed_rows[i].rep);
      run_random(PHASE_CHARS);
      drain_reports();

      send_idle_pct = 73;
      recv_idle_pct = 19;
      run_random(PHASE_CHARS);
      drain_reports();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_CHARS);
      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
